FILE: hdl/tasep_gillespie_step_unit_defines.svh
// Assertion macros for the TASEP event unit.
// Both expect clk and rst_n in scope.
`ifndef TASEP_GILLESPIE_STEP_UNIT_DEFINES_SVH
`define TASEP_GILLESPIE_STEP_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TGS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);
`else
`define TGS_ASSERT(lbl, prop, msg)
`define TGS_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

FILE: hdl/tgs_pkg.sv
package tgs_pkg;

  localparam int RATE_W = 16;
  localparam int FP_W   = 6;
  localparam int WIN_W  = 63;   // largest look-ahead window
  localparam int OUT_TOT_W = 25;
  localparam int OUT_CNT_W = 9;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;
  localparam logic [FP_W-1:0]   FP_RESET   = 6'd9;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_HOP   = 2'd1;
  localparam logic [1:0] KIND_EXIT  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] CFG_ENTRY_RATE = 2'd0;
  localparam logic [1:0] CFG_EXIT_RATE  = 2'd1;
  localparam logic [1:0] CFG_FOOTPRINT  = 2'd2;

  typedef struct packed {
    logic shift;     // rotate ring one place toward site 0
    logic occ_set;
    logic occ_clr;
    logic rate_we;
  } cell_ctl_t;

endpackage

FILE: hdl/tgs_cell.sv
module tgs_cell import tgs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              nbr_occ,
  input  logic [RATE_W-1:0] nbr_rate,
  input  logic [RATE_W-1:0] wr_rate,
  output logic              occ,
  output logic [RATE_W-1:0] rate
);

  logic              occ_r, occ_nxt, occ_base;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  always_comb begin
    occ_base = ctl.shift ? nbr_occ : occ_r;
    // set/clear act on the word arriving in this cell
    occ_nxt  = (occ_base | ctl.occ_set) & ~ctl.occ_clr;
    if (ctl.rate_we) begin
      rate_nxt = wr_rate;
    end else if (ctl.shift) begin
      rate_nxt = nbr_rate;
    end else begin
      rate_nxt = rate_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      rate_r <= RATE_RESET;
    end else begin
      occ_r  <= occ_nxt;
      rate_r <= rate_nxt;
    end
  end

  assign occ  = occ_r;
  assign rate = rate_r;

endmodule

FILE: hdl/tgs_window.sv
module tgs_window import tgs_pkg::*; (
  input  logic [WIN_W-1:0] win_occ,   // bit k-1 is the site k places ahead of the head
  input  logic [FP_W-1:0]  lim,
  output logic             blocked
);

  logic [WIN_W-1:0] mask;

  // sites 1..lim ahead are checked
  assign mask    = ~(WIN_W'({WIN_W{1'b1}}) << lim);
  assign blocked = |(win_occ & mask);

endmodule

FILE: hdl/tasep_gillespie_step_unit.sv
// TASEP event unit: one Gillespie event of an exclusion process with extended
// particles on a ring of SITES cells, each holding one site's occupancy and hop rate.
// Input channel (in_valid / in_stall): op 0 runs one event using uniform_draw,
// op 1 loads the hop rate of one site. One word in flight at a time.
// Result channel (out_valid / out_stall): one word per input word, held in an
// output register; the next input word is taken while a result waits.
// Config channel (cfg_valid / cfg_ready): entry rate, exit rate, footprint; always ready.
// A rate load goes from IDLE straight to DONE. An event runs a sum pass (TOT_E,
// TOT), MUL, a select pass (SEL_E, SEL) and DONE, skipping MUL and the select
// pass when nothing is enabled. The ring is rotated one site per cycle, once to
// sum enabled rates and, for a nonzero total, once more to select the move.
// Reset (rst_n, synchronous): lattice empty, all hop rates 256, entry and exit
// rates 256, footprint 9; no result pending.
// A stalled result simply waits in the output register; the block finishes the
// current event, then holds it until the output register frees up.
`include "tasep_gillespie_step_unit_defines.svh"
module tasep_gillespie_step_unit import tgs_pkg::*; #(
  parameter int SITES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_site,
  input  logic [15:0] in_rate_value,
  input  logic [15:0] in_uniform_draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_moved_from,
  output logic [24:0] out_total_rate,
  output logic        out_finished,
  output logic [8:0]  out_particle_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (SITES > 1) ? $clog2(SITES) : 1;
  localparam int TOT_W = RATE_W + $clog2(SITES + 1);
  localparam int CNT_W = $clog2(SITES + 1);
  localparam int TGT_W = TOT_W + 16;
  localparam int EXT_W = IDX_W + FP_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SITES - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TOT_E = 3'd1;
  localparam logic [2:0] ST_TOT   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SEL_E = 3'd4;
  localparam logic [2:0] ST_SEL   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [TOT_W-1:0]  cum_r, cum_nxt;
  logic [TGT_W-1:0]  target_r, target_nxt;
  logic [15:0]       u_r, u_nxt;
  logic              done_r, done_nxt;
  logic              entry_ok_r, entry_ok_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [IDX_W-1:0]  from_r, from_nxt;
  logic              fin_r, fin_nxt;
  logic [RATE_W-1:0] er_r, er_nxt;
  logic [RATE_W-1:0] xr_r, xr_nxt;
  logic [FP_W-1:0]   fp_r, fp_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [7:0]        out_from_r, out_from_nxt;
  logic [24:0]       out_total_r, out_total_nxt;
  logic              out_fin_r, out_fin_nxt;
  logic [8:0]        out_count_r, out_count_nxt;

  // ring
  logic [SITES-1:0]  occ_vec;
  logic [RATE_W-1:0] rate_arr [SITES];
  logic [WIN_W-1:0]  win_occ;
  logic              ring_shift, set_head, clr_tail, load_we;

  genvar gi;
  generate
    for (gi = 0; gi < SITES; gi++) begin : g_ring
      localparam logic [IDX_W+7:0] SITE_ID = (IDX_W + 8)'(gi);
      cell_ctl_t ctl;
      assign ctl.shift   = ring_shift;
      assign ctl.occ_set = (gi == 0) ? set_head : 1'b0;
      assign ctl.occ_clr = (gi == SITES - 1) ? clr_tail : 1'b0;
      assign ctl.rate_we = load_we && ((IDX_W + 8)'(in_site) == SITE_ID);
      tgs_cell u_site (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .nbr_occ  (occ_vec[(gi + 1) % SITES]),
        .nbr_rate (rate_arr[(gi + 1) % SITES]),
        .wr_rate  (in_rate_value),
        .occ      (occ_vec[gi]),
        .rate     (rate_arr[gi])
      );
    end
    for (gi = 1; gi <= WIN_W; gi++) begin : g_win
      if (gi < SITES) begin : g_real
        assign win_occ[gi-1] = occ_vec[gi];
      end else begin : g_pad
        assign win_occ[gi-1] = 1'b0;
      end
    end
  endgenerate

  // look-ahead window, clipped at the exit end
  logic [FP_W-1:0]  fp_eff, lim;
  logic [IDX_W-1:0] rem;
  logic [EXT_W-1:0] rem_ext;
  logic             blocked;

  assign fp_eff  = (fp_r == '0) ? FP_W'(1) : fp_r;
  assign rem     = LAST - pos_r;
  assign rem_ext = EXT_W'(rem);
  assign lim     = (rem_ext < EXT_W'(fp_eff)) ? rem_ext[FP_W-1:0] : fp_eff;

  tgs_window u_win (
    .win_occ (win_occ),
    .lim     (lim),
    .blocked (blocked)
  );

  logic              at_last, head_occ;
  logic [RATE_W-1:0] move_rate, cand;
  logic [TOT_W-1:0]  cum_add, entry_cum;
  logic              sel_hit, entry_hit, in_acc, out_free;

  assign at_last   = (pos_r == LAST);
  assign head_occ  = occ_vec[0];
  assign move_rate = at_last ? xr_r : (blocked ? '0 : rate_arr[0]);
  assign cand      = head_occ ? move_rate : '0;
  assign cum_add   = cum_r + TOT_W'(cand);
  assign sel_hit   = !done_r && (cand != '0) && ({cum_add, 16'h0} >= target_r);
  assign entry_cum = entry_ok_r ? TOT_W'(er_r) : '0;
  assign entry_hit = entry_ok_r && (er_r != '0) && ({entry_cum, 16'h0} >= target_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // widened views for the result word; total and count are saturated
  logic [TOT_W+OUT_TOT_W-1:0] tot_ext;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_ext;
  logic [IDX_W+7:0]           from_ext;

  assign tot_ext  = (TOT_W + OUT_TOT_W)'(total_r);
  assign cnt_ext  = (CNT_W + OUT_CNT_W)'(count_r);
  assign from_ext = (IDX_W + 8)'(from_r);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    total_nxt    = total_r;
    cum_nxt      = cum_r;
    target_nxt   = target_r;
    u_nxt        = u_r;
    done_nxt     = done_r;
    entry_ok_nxt = entry_ok_r;
    count_nxt    = count_r;
    kind_nxt     = kind_r;
    from_nxt     = from_r;
    fin_nxt      = fin_r;
    er_nxt       = er_r;
    xr_nxt       = xr_r;
    fp_nxt       = fp_r;
    ring_shift   = 1'b0;
    set_head     = 1'b0;
    clr_tail     = 1'b0;
    load_we      = 1'b0;

    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_from_nxt  = out_from_r;
    out_total_nxt = out_total_r;
    out_fin_nxt   = out_fin_r;
    out_count_nxt = out_count_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ENTRY_RATE: er_nxt = cfg_data;
        CFG_EXIT_RATE:  xr_nxt = cfg_data;
        CFG_FOOTPRINT:  fp_nxt = cfg_data[FP_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_nxt  = KIND_NONE;
          from_nxt  = '0;
          fin_nxt   = 1'b0;
          total_nxt = '0;
          cum_nxt   = '0;
          done_nxt  = 1'b0;
          pos_nxt   = '0;
          u_nxt     = in_uniform_draw;
          if (in_op == OP_LOAD) begin
            load_we   = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_TOT_E;
          end
        end
      end
      ST_TOT_E: begin
        // ring aligned: head is site 0
        entry_ok_nxt = !head_occ && !blocked;
        total_nxt    = (!head_occ && !blocked) ? TOT_W'(er_r) : '0;
        state_nxt    = ST_TOT;
      end
      ST_TOT: begin
        ring_shift = 1'b1;
        total_nxt  = total_r + TOT_W'(cand);
        pos_nxt    = at_last ? '0 : pos_r + 1'b1;
        if (at_last) begin
          state_nxt = (total_nxt == '0) ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        target_nxt = TGT_W'(u_r) * TGT_W'(total_r);
        state_nxt  = ST_SEL_E;
      end
      ST_SEL_E: begin
        cum_nxt = entry_cum;
        if (entry_hit) begin
          set_head  = 1'b1;
          kind_nxt  = KIND_ENTRY;
          done_nxt  = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        ring_shift = 1'b1;
        cum_nxt    = cum_add;
        pos_nxt    = at_last ? '0 : pos_r + 1'b1;
        if (sel_hit) begin
          done_nxt = 1'b1;
          from_nxt = pos_r;
          clr_tail = 1'b1;   // head word wraps to the tail cell
          if (at_last) begin
            kind_nxt  = KIND_EXIT;
            fin_nxt   = 1'b1;
            count_nxt = count_r - 1'b1;
          end else begin
            kind_nxt = KIND_HOP;
            set_head = 1'b1;
          end
        end
        if (at_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_from_nxt  = from_ext[7:0];
          out_total_nxt = (tot_ext > (TOT_W + OUT_TOT_W)'({OUT_TOT_W{1'b1}})) ?
                          {OUT_TOT_W{1'b1}} : tot_ext[OUT_TOT_W-1:0];
          out_fin_nxt   = fin_r;
          out_count_nxt = (cnt_ext > (CNT_W + OUT_CNT_W)'({OUT_CNT_W{1'b1}})) ?
                          {OUT_CNT_W{1'b1}} : cnt_ext[OUT_CNT_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      done_r      <= 1'b0;
      count_r     <= '0;
      er_r        <= RATE_RESET;
      xr_r        <= RATE_RESET;
      fp_r        <= FP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      count_r     <= count_nxt;
      er_r        <= er_nxt;
      xr_r        <= xr_nxt;
      fp_r        <= fp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r     <= total_nxt;
    cum_r       <= cum_nxt;
    target_r    <= target_nxt;
    u_r         <= u_nxt;
    entry_ok_r  <= entry_ok_nxt;
    kind_r      <= kind_nxt;
    from_r      <= from_nxt;
    fin_r       <= fin_nxt;
    out_kind_r  <= out_kind_nxt;
    out_from_r  <= out_from_nxt;
    out_total_r <= out_total_nxt;
    out_fin_r   <= out_fin_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_kind_r;
  assign out_moved_from     = out_from_r;
  assign out_total_rate     = out_total_r;
  assign out_finished       = out_fin_r;
  assign out_particle_count = out_count_r;

  `TGS_ASSERT_NEXT(a_pos_step, (state_r == ST_SEL && !at_last), pos_r == $past(pos_r) + 1'b1, "select pass skipped a site")
  `TGS_ASSERT_NEXT(a_one_pick, (state_r == ST_SEL && done_r), done_r, "selection flag dropped mid pass")
  `TGS_ASSERT_NEXT(a_pick_made, (state_r == ST_SEL && at_last), done_r, "nonzero total but no move selected")
  `TGS_ASSERT(a_cnt_bound, count_r <= CNT_W'(SITES), "particle count above lattice size")
  `TGS_ASSERT(a_fin_exit, out_valid_r |-> (out_fin_r == (out_kind_r == KIND_EXIT)), "finished flag disagrees with kind")

endmodule
